/* rtl/stq_pkg.sv */
// Shared types, constants and command codes for the sorted timeout queue.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TIME_W  = 64;
  localparam int TOUT_W  = 31;
  localparam int WAIT_W  = 32;
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REAPPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd4;

  // Operation that the top level broadcasts to every cell.
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_REMOVE = 2'd1;
  localparam logic [1:0] CELL_INSERT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [TOUT_W-1:0] timeout;
  } stq_cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              head_valid;
    logic [SLOT_W-1:0] head_slot;
    logic [WAIT_W-1:0] wait_time;
    logic              expired;
    logic [CNT_W-1:0]  armed_count;
  } stq_result_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] deadline;
  } stq_entry_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] deadline;
  } stq_cell_ctrl_t;

endpackage

/* rtl/sorted_timeout_queue_core.sv */
// Top level of the sorted timeout queue: command sequencer, time counter and row of cells.
// The strobe rises after the remove, insert and evaluate steps, as the sequencer returns to idle.
// Busy is high for the three sequencer steps; a new item is taken only once the last is through.
// The cell row moves one entry per cell per step, so every command costs the same.
// Reset clears the time counter, the armed flags, the count and all cell valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module sorted_timeout_queue_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  stq_pkg::stq_cmd_t    cmd_i,
  output logic                 busy,
  output logic                 done_o,
  output stq_pkg::stq_result_t result_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REMOVE = 2'd1;
  localparam logic [1:0] ST_INSERT = 2'd2;
  localparam logic [1:0] ST_EVAL   = 2'd3;

  logic [1:0]                    state_q, state_d;
  stq_pkg::stq_cmd_t             cmd_q;
  logic [stq_pkg::TIME_W-1:0]    time_q;
  logic [stq_pkg::TIME_W-1:0]    dl_q;
  logic [stq_pkg::SLOTS-1:0]     armed_q;
  logic [stq_pkg::CNT_W-1:0]     count_q;
  logic                          acc_q;
  logic                          done_q;
  stq_pkg::stq_result_t          result_q, result_d;

  logic                          slot_ok;
  logic                          is_remove;
  logic                          is_insert;
  logic                          rem_go;
  logic                          ins_go;
  stq_pkg::stq_cell_ctrl_t       ctrl;

  stq_pkg::stq_entry_t           ent   [stq_pkg::SLOTS];
  logic                          le    [stq_pkg::SLOTS];
  logic                          shift [stq_pkg::SLOTS+1];
  stq_pkg::stq_entry_t           empty_ent;
  logic                          head_due;
  logic [stq_pkg::TIME_W-1:0]    head_diff;

  assign slot_ok   = int'(cmd_q.slot) < stq_pkg::SLOTS;
  assign is_remove = (cmd_q.command == stq_pkg::CMD_DELETE) ||
                     (cmd_q.command == stq_pkg::CMD_REAPPEND);
  assign is_insert = (cmd_q.command == stq_pkg::CMD_APPEND) ||
                     (cmd_q.command == stq_pkg::CMD_REAPPEND);
  assign rem_go    = (state_q == ST_REMOVE) && is_remove && slot_ok && armed_q[cmd_q.slot];
  assign ins_go    = (state_q == ST_INSERT) && is_insert && slot_ok && !armed_q[cmd_q.slot] &&
                     (count_q < stq_pkg::CNT_W'(stq_pkg::SLOTS));

  always_comb begin
    ctrl.slot     = cmd_q.slot;
    ctrl.deadline = dl_q;
    if (rem_go) begin
      ctrl.op = stq_pkg::CELL_REMOVE;
    end else if (ins_go) begin
      ctrl.op = stq_pkg::CELL_INSERT;
    end else begin
      ctrl.op = stq_pkg::CELL_HOLD;
    end
  end

  assign empty_ent.valid    = 1'b0;
  assign empty_ent.slot     = '0;
  assign empty_ent.deadline = '0;
  assign shift[0]           = 1'b0;

  for (genvar i = 0; i < stq_pkg::SLOTS; i++) begin : g_cell
    stq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    ((i == 0) ? empty_ent : ent[(i == 0) ? 0 : i - 1]),
      .right_i   ((i == stq_pkg::SLOTS - 1) ? empty_ent
                                            : ent[(i == stq_pkg::SLOTS - 1) ? i : i + 1]),
      .left_le_i ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
      .shift_i   (shift[i]),
      .ent_o     (ent[i]),
      .le_o      (le[i]),
      .shift_o   (shift[i+1])
    );
  end

  // Head of the row is the earliest deadline; the due test compares full 64-bit values.
  assign head_due  = ent[0].deadline <= time_q;
  assign head_diff = ent[0].deadline - time_q;

  always_comb begin
    result_d.accepted    = acc_q;
    result_d.armed_count = count_q;
    if (ent[0].valid) begin
      result_d.head_valid = 1'b1;
      result_d.head_slot  = ent[0].slot;
      result_d.wait_time  = head_due ? '0 : head_diff[stq_pkg::WAIT_W-1:0];
      result_d.expired    = head_due;
    end else begin
      result_d.head_valid = 1'b0;
      result_d.head_slot  = '0;
      result_d.wait_time  = '1;
      result_d.expired    = 1'b0;
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE:   state_d = start ? ST_REMOVE : ST_IDLE;
      ST_REMOVE: state_d = ST_INSERT;
      ST_INSERT: state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      time_q  <= '0;
      armed_q <= '0;
      count_q <= '0;
      acc_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_EVAL);
      if ((state_q == ST_REMOVE) && (cmd_q.command == stq_pkg::CMD_TICK)) begin
        time_q <= time_q + stq_pkg::TIME_W'(1);
      end
      if (rem_go) begin
        armed_q[cmd_q.slot] <= 1'b0;
        count_q             <= count_q - stq_pkg::CNT_W'(1);
      end
      if (state_q == ST_INSERT) begin
        acc_q <= ins_go;
      end
      if (ins_go) begin
        armed_q[cmd_q.slot] <= 1'b1;
        count_q             <= count_q + stq_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_REMOVE) begin
      dl_q <= time_q + stq_pkg::TIME_W'(cmd_q.timeout);
    end
    if (state_q == ST_EVAL) begin
      result_q <= result_d;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= stq_pkg::CNT_W'(stq_pkg::SLOTS))
    else $error("armed count exceeds the number of slots");

  a_count_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(armed_q) == int'(count_q)))
    else $error("armed flags disagree with the armed count");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while an item is still in work");

  a_head_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (result_q.head_valid == (result_q.armed_count != '0)))
    else $error("head valid disagrees with the armed count");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_q))
    else $error("accepted item did not make the sequencer busy");
`endif

endmodule

/* rtl/stq_cell.sv */
// One position of the sorted timer row: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
module stq_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stq_pkg::stq_cell_ctrl_t ctrl_i,
  input  stq_pkg::stq_entry_t    left_i,
  input  stq_pkg::stq_entry_t    right_i,
  input  logic                   left_le_i,
  input  logic                   shift_i,
  output stq_pkg::stq_entry_t    ent_o,
  output logic                   le_o,
  output logic                   shift_o
);

  logic                           valid_q, valid_d;
  logic [stq_pkg::SLOT_W-1:0]     slot_q, slot_d;
  logic [stq_pkg::TIME_W-1:0]     deadline_q, deadline_d;
  logic                           hit;
  logic                           le;

  assign hit = valid_q && (slot_q == ctrl_i.slot);
  // Entries are sorted, so the cells with le set always form a prefix of the row.
  assign le  = valid_q && (deadline_q <= ctrl_i.deadline);

  assign le_o    = le;
  assign shift_o = shift_i || hit;

  assign ent_o.valid    = valid_q;
  assign ent_o.slot     = slot_q;
  assign ent_o.deadline = deadline_q;

  always_comb begin
    valid_d    = valid_q;
    slot_d     = slot_q;
    deadline_d = deadline_q;
    case (ctrl_i.op)
      stq_pkg::CELL_REMOVE: begin
        if (shift_i || hit) begin
          valid_d    = right_i.valid;
          slot_d     = right_i.slot;
          deadline_d = right_i.deadline;
        end
      end
      stq_pkg::CELL_INSERT: begin
        if (!le) begin
          if (left_le_i) begin
            valid_d    = 1'b1;
            slot_d     = ctrl_i.slot;
            deadline_d = ctrl_i.deadline;
          end else begin
            valid_d    = left_i.valid;
            slot_d     = left_i.slot;
            deadline_d = left_i.deadline;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    deadline_q <= deadline_d;
  end

endmodule

/* sim/sorted_timeout_queue_checker.sv */
// Checker that predicts every head report of the sorted timeout queue and compares it.
`timescale 1ns / 1ps
module sorted_timeout_queue_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  stq_pkg::stq_cmd_t    cmd_i,
  input  logic                 done_i,
  input  stq_pkg::stq_result_t result_i,
  output int                   error_count_o,
  output int                   pending_o,
  output int                   report_count_o,
  output int                   expired_count_o,
  output int                   full_count_o
);
  import stq_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] deadline;
  } timer_t;

  logic [TIME_W-1:0] now_ticks;
  logic [SLOTS-1:0]  slot_armed;
  timer_t            timer_list[$];
  stq_result_t       head_report_q[$];
  int                error_count;
  int                report_count;
  int                expired_count;
  int                full_count;

  initial begin
    error_count   = 0;
    report_count  = 0;
    expired_count = 0;
    full_count    = 0;
    pending_o     = 0;
  end

  assign error_count_o   = error_count;
  assign report_count_o  = report_count;
  assign expired_count_o = expired_count;
  assign full_count_o    = full_count;

  function automatic void disarm_slot(logic [SLOT_W-1:0] s);
    if (!slot_armed[s]) return;
    for (int i = 0; i < timer_list.size(); i++) begin
      if (timer_list[i].slot == s) begin
        timer_list.delete(i);
        break;
      end
    end
    slot_armed[s] = 1'b0;
  endfunction

  // A new timer goes behind every entry whose deadline is at or before its own.
  function automatic logic arm_slot(logic [SLOT_W-1:0] s, logic [TOUT_W-1:0] t);
    timer_t e;
    int     pos;
    if (slot_armed[s] || timer_list.size() >= SLOTS) return 1'b0;
    e.slot     = s;
    e.deadline = now_ticks + TIME_W'(t);
    pos = 0;
    while (pos < timer_list.size() && timer_list[pos].deadline <= e.deadline) pos++;
    timer_list.insert(pos, e);
    slot_armed[s] = 1'b1;
    return 1'b1;
  endfunction

  function automatic stq_result_t apply_timer_cmd(stq_cmd_t c);
    stq_result_t r;
    logic        acc;
    acc = 1'b0;
    case (c.command)
      CMD_APPEND: begin
        acc = arm_slot(c.slot, c.timeout);
      end
      CMD_DELETE: begin
        disarm_slot(c.slot);
      end
      CMD_REAPPEND: begin
        disarm_slot(c.slot);
        acc = arm_slot(c.slot, c.timeout);
      end
      CMD_TICK: begin
        now_ticks = now_ticks + TIME_W'(1);
      end
      default: begin
      end
    endcase
    r = '0;
    r.accepted    = acc;
    r.armed_count = CNT_W'(timer_list.size());
    if (timer_list.size() == 0) begin
      r.wait_time = '1;
    end else begin
      r.head_valid = 1'b1;
      r.head_slot  = timer_list[0].slot;
      if (timer_list[0].deadline <= now_ticks) begin
        r.expired = 1'b1;
      end else begin
        r.wait_time = WAIT_W'(timer_list[0].deadline - now_ticks);
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stq_result_t want;
    if (!rst_ni) begin
      now_ticks  = '0;
      slot_armed = '0;
      timer_list.delete();
      head_report_q.delete();
      pending_o <= 0;
    end else begin
      if (start_i && !busy_i) head_report_q.push_back(apply_timer_cmd(cmd_i));
      if (done_i) begin
        if (head_report_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, result_i);
        end else begin
          want = head_report_q.pop_front();
          report_count++;
          if (want.expired) expired_count++;
          if (want.armed_count == CNT_W'(SLOTS)) full_count++;
          check_field("accepted", 64'(want.accepted), 64'(result_i.accepted));
          check_field("head_valid", 64'(want.head_valid), 64'(result_i.head_valid));
          check_field("head_slot", 64'(want.head_slot), 64'(result_i.head_slot));
          check_field("wait_time", 64'(want.wait_time), 64'(result_i.wait_time));
          check_field("expired", 64'(want.expired), 64'(result_i.expired));
          check_field("armed_count", 64'(want.armed_count), 64'(result_i.armed_count));
        end
      end
      pending_o <= head_report_q.size();
    end
  end

endmodule

/* sim/sorted_timeout_queue_core_test.sv */
// Testbench top for the sorted timeout queue: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module sorted_timeout_queue_core_test;
  import stq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS  = 1830;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 12;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  stq_cmd_t    cmd_i  = '0;
  logic        busy;
  logic        done_o;
  stq_result_t result_o;

  int error_count;
  int pending;
  int report_count;
  int expired_count;
  int full_count;
  int items_sent  = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  sorted_timeout_queue_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  sorted_timeout_queue_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd_i),
    .done_i          (done_o),
    .result_i        (result_o),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .report_count_o  (report_count),
    .expired_count_o (expired_count),
    .full_count_o    (full_count)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Start stays high into the next item when the gap is zero, so it is only
  // lowered when the sender actually pauses.
  task automatic issue_cmd(input logic [CMD_W-1:0] op, input logic [SLOT_W-1:0] s,
                           input logic [TOUT_W-1:0] t, input int gap, input bit drain);
    stq_cmd_t c;
    c.command = op;
    c.slot    = s;
    c.timeout = t;
    cmd_i <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (drain) begin
      // The checker counts this item as pending only from the next edge on.
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    int                append_pct;
    bit                quiet;
    int                r;
    logic [CMD_W-1:0]  op;
    logic [TOUT_W-1:0] t;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty queue, due and maximal deadlines, refusals, ties.
    issue_cmd(CMD_QUERY, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_DELETE, 4'hF, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_APPEND, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_APPEND, 4'd0, 31'd5, pick_gap(0), 0);
    issue_cmd(CMD_APPEND, 4'hF, 31'h7FFF_FFFF, pick_gap(0), 0);
    issue_cmd(CMD_APPEND, 4'd5, 31'd3, pick_gap(0), 0);
    issue_cmd(CMD_APPEND, 4'd9, 31'd3, pick_gap(0), 0);
    issue_cmd(CMD_DELETE, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_TICK, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_TICK, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_TICK, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_REAPPEND, 4'd5, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_REAPPEND, 4'd7, 31'd2, pick_gap(0), 0);
    for (int k = int'(CMD_SPARE_LO); k <= int'(CMD_SPARE_HI); k++) begin
      issue_cmd(CMD_W'(k), 4'hF, 31'h7FFF_FFFF, pick_gap(0), 0);
    end
    issue_cmd(CMD_DELETE, 4'd9, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_DELETE, 4'd5, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_DELETE, 4'd7, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_DELETE, 4'hF, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_TICK, 4'd0, 31'd0, pick_gap(0), 0);
    issue_cmd(CMD_QUERY, 4'd0, 31'd0, pick_gap(0), 1);

    // Random part in episodes that differ in how hard they fill the queue.
    append_pct = 35;
    quiet      = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        r = $urandom_range(0, 2);
        append_pct = (r == 0) ? 15 : (r == 1) ? 35 : 60;
        quiet      = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < append_pct) begin
        op = CMD_APPEND;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 28)      op = CMD_DELETE;
        else if (r < 50) op = CMD_REAPPEND;
        else if (r < 88) op = CMD_TICK;
        else if (r < 96) op = CMD_QUERY;
        else             op = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      // Short timeouts let ticks reach deadlines and make ties common.
      r = $urandom_range(0, 99);
      if (r < 50)      t = TOUT_W'($urandom_range(0, 8));
      else if (r < 75) t = TOUT_W'($urandom_range(0, 300));
      else if (r < 92) t = TOUT_W'($urandom);
      else             t = 31'h7FFF_FFFF - TOUT_W'($urandom_range(0, 3));
      issue_cmd(op, SLOT_W'($urandom_range(0, SLOTS - 1)), t, pick_gap(quiet),
                (n % 300 == 299) || (n == RANDOM_ITEMS - 1));
    end

    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("summary: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, report_count, error_count);
    $display("summary: %0d results with a due head, %0d with every slot armed",
             expired_count, full_count);
    if (error_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
